FILE: src/itab_pkg.sv
package itab_pkg;

  localparam int NUMBER_WIDTH = 32;
  localparam int RADIX_WIDTH  = 8;
  localparam int CHAR_WIDTH   = 7;

  // Long division by the radix handles this many quotient bits per cycle.
  localparam int DIV_STEP   = 8;
  localparam int DIV_PASSES = (NUMBER_WIDTH + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W      = DIV_PASSES * DIV_STEP;
  localparam int PASS_W     = $clog2(DIV_PASSES + 1);

  localparam int BASE_W  = 5;
  localparam int DIGIT_W = 4;

  // At most one digit per bit of the value (radix 2).
  localparam int STACK_DEPTH = NUMBER_WIDTH;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = RADIX_WIDTH'(2);
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = RADIX_WIDTH'(16);
  localparam logic [BASE_W-1:0]      BASE_DEC  = BASE_W'(10);

  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = CHAR_WIDTH'(8'h2D);
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = CHAR_WIDTH'(8'h30);
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOW_A = CHAR_WIDTH'(8'h61);

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } itab_cmd_t;

  typedef struct packed {
    logic last_pass;
    logic quot_zero;
    logic negative;
    logic one_left;
    logic out_free;
  } itab_sts_t;

  function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_WIDTH'(d);
    end else begin
      c = CHAR_LOW_A + CHAR_WIDTH'(d - DIGIT_W'(10));
    end
    return c;
  endfunction

endpackage

FILE: src/itab_in_if.sv
interface itab_in_if;
  import itab_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] number;
  logic [RADIX_WIDTH-1:0]  radix;
  logic                    as_signed;

  modport source (output valid, output number, output radix, output as_signed, input ready);
  modport sink   (input valid, input number, input radix, input as_signed, output ready);
endinterface

FILE: src/itab_out_if.sv
interface itab_out_if;
  import itab_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] text_char;
  logic                  is_last;

  modport source (output valid, output text_char, output is_last, input ready);
  modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

FILE: src/itab_ctrl.sv
module itab_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  itab_pkg::itab_sts_t sts,
  output itab_pkg::itab_cmd_t cmd
);
  import itab_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_EMIT} state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        // The quotient reaching zero on the last pass means this step pushes the last digit.
        if (sts.last_pass && sts.quot_zero) begin
          state_nxt = sts.negative ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.one_left) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/itab_dp.sv
module itab_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [itab_pkg::NUMBER_WIDTH-1:0]     in_number,
  input  logic [itab_pkg::RADIX_WIDTH-1:0]      in_radix,
  input  logic                                  in_as_signed,
  input  itab_pkg::itab_cmd_t                   cmd,
  output itab_pkg::itab_sts_t                   sts,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [itab_pkg::CHAR_WIDTH-1:0]       out_text_char,
  output logic                                  out_is_last
);
  import itab_pkg::*;

  logic [DIV_W-1:0]      val_r;
  logic [BASE_W-1:0]     base_r;
  logic [DIGIT_W-1:0]    rem_r;
  logic [PASS_W-1:0]     pass_r;
  logic                  neg_r;
  logic [DIGIT_W-1:0]    stack_r [STACK_DEPTH];
  logic [DEPTH_W-1:0]    depth_r;
  logic                  out_valid_r;
  logic [CHAR_WIDTH-1:0] char_r;
  logic                  last_r;

  logic                    in_neg;
  logic [NUMBER_WIDTH-1:0] in_mag;
  logic [BASE_W-1:0]       in_base;
  logic [DIGIT_W-1:0]      rem_nxt;
  logic [DIV_STEP-1:0]     qbits;
  logic [DIV_W-1:0]        val_nxt;
  logic                    last_pass;

  assign in_neg = in_as_signed & in_number[NUMBER_WIDTH-1];
  assign in_mag = in_neg ? (~in_number + NUMBER_WIDTH'(1)) : in_number;

  always_comb begin
    if (in_as_signed || in_radix < RADIX_MIN || in_radix > RADIX_MAX) begin
      in_base = BASE_DEC;
    end else begin
      in_base = in_radix[BASE_W-1:0];
    end
  end

  // Restoring long division, DIV_STEP bits of the dividend per cycle. The
  // remainder stays below the radix, so each step is a 5-bit compare.
  always_comb begin
    logic [BASE_W-1:0] t;
    rem_nxt = rem_r;
    qbits   = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      t = {rem_nxt, val_r[DIV_W - DIV_STEP + i]};
      if (t >= base_r) begin
        qbits[i] = 1'b1;
        t        = t - base_r;
      end
      rem_nxt = t[DIGIT_W-1:0];
    end
  end

  // Quotient bits enter at the bottom as dividend bits leave the top.
  assign val_nxt   = (val_r << DIV_STEP) | DIV_W'(qbits);
  assign last_pass = (pass_r == PASS_W'(DIV_PASSES - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r  <= DIV_W'(in_mag);
      base_r <= in_base;
      neg_r  <= in_neg;
      rem_r  <= '0;
      pass_r <= '0;
    end else if (cmd.div_step) begin
      val_r <= val_nxt;
      if (last_pass) begin
        rem_r  <= '0;
        pass_r <= '0;
      end else begin
        rem_r  <= rem_nxt;
        pass_r <= pass_r + PASS_W'(1);
      end
    end
  end

  // Digit stack: pushed least significant first, popped most significant first.
  always_ff @(posedge clk) begin
    if (cmd.div_step && last_pass) begin
      stack_r[0] <= rem_nxt;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stack_r[i] <= stack_r[i-1];
      end
    end else if (cmd.emit_digit) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stack_r[i] <= stack_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.load) begin
      depth_r <= '0;
    end else if (cmd.div_step && last_pass) begin
      depth_r <= depth_r + DEPTH_W'(1);
    end else if (cmd.emit_digit) begin
      depth_r <= depth_r - DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      char_r <= CHAR_MINUS;
      last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_r <= digit_char(stack_r[0]);
      last_r <= (depth_r == DEPTH_W'(1));
    end
  end

  assign sts.last_pass = last_pass;
  assign sts.quot_zero = (val_nxt == '0);
  assign sts.negative  = neg_r;
  assign sts.one_left  = (depth_r == DEPTH_W'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_text_char = char_r;
  assign out_is_last   = last_r;

endmodule

FILE: src/integer_to_text_any_base.sv
// Integer to text converter for radix 2 to 16.
// An item on in_if carries a value, a radix and a signed flag; out_if then
// delivers the value's ASCII text one character per item, most significant
// digit first, with is_last set on the final character. Signed mode writes
// decimal with a leading '-' for negative values; a radix outside 2..16
// is taken as 10.
// One item is converted at a time. Each digit costs one long division by the
// radix, done 8 dividend bits per cycle; characters then leave one per cycle
// from a digit stack while out_if.ready is high. in_if.ready is high only
// while the converter is idle.
// The output register lets the last character of one item wait while the
// next item is accepted. When out_if.ready is low, emission stops and holds.
// Synchronous reset empties the output register and returns to idle.
module integer_to_text_any_base (
  input  logic        clk,
  input  logic        rst_n,
  itab_in_if.sink     in_if,
  itab_out_if.source  out_if
);
  import itab_pkg::*;

  itab_cmd_t cmd;
  itab_sts_t sts;

  itab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itab_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_number     (in_if.number),
    .in_radix      (in_if.radix),
    .in_as_signed  (in_if.as_signed),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_text_char (out_if.text_char),
    .out_is_last   (out_if.is_last)
  );

endmodule

FILE: src/itab_check.sv
module itab_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [itab_pkg::CHAR_WIDTH-1:0] out_text_char,
  input logic                            out_is_last
);
  import itab_pkg::*;

  // The converter is not ready again in the cycle after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // While idle, a character still waiting must be the end of the last text.
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_is_last)
    else $error("idle with an unfinished text pending");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_char == CHAR_MINUS |-> !out_is_last)
    else $error("minus sign marked as last character");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_text_char))
    else $error("stalled character dropped or changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind integer_to_text_any_base itab_check u_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_text_char (out_if.text_char),
  .out_is_last   (out_if.is_last)
);

FILE: tb/sv/tb_integer_to_text_any_base.sv
module tb_integer_to_text_any_base;
  timeunit 1ns;
  timeprecision 1ps;

  import itab_pkg::*;

  localparam int MAX_WAIT     = 19;
  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_COUNT = 300;
  localparam int BURST_COUNT  = 40;
  localparam int HOLD_COUNT   = 12;

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_WIDTH-1:0] ASCII_LOW_A = 7'h61;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] text_char;
    logic                  is_last;
  } text_char_t;

  logic clk;
  logic rst_n;

  itab_in_if  in_ch ();
  itab_out_if out_ch ();

  integer_to_text_any_base dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  text_char_t pending_chars[$];
  int         mismatch_count;
  int         numbers_sent;
  int         chars_checked;
  int         holds_done;
  int         stuck_cycles;
  bit         no_gaps;
  bit         hold_request;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Expected text of one number, most significant digit first.
  function automatic void predict_text(input logic [NUMBER_WIDTH-1:0] num,
                                       input logic [RADIX_WIDTH-1:0] rdx,
                                       input logic sgn);
    logic [NUMBER_WIDTH-1:0] magnitude;
    logic [NUMBER_WIDTH-1:0] base;
    logic [NUMBER_WIDTH-1:0] digit;
    logic [CHAR_WIDTH-1:0]   digits_low_first[$];
    logic                    negative;
    text_char_t              entry;
    magnitude = num;
    negative  = 1'b0;
    if (rdx < RADIX_MIN || rdx > RADIX_MAX) begin
      base = 10;
    end else begin
      base = NUMBER_WIDTH'(rdx);
    end
    if (sgn) begin
      base = 10;
      if (num[NUMBER_WIDTH-1]) begin
        negative  = 1'b1;
        magnitude = ~num + NUMBER_WIDTH'(1);
      end
    end
    do begin
      digit = magnitude % base;
      if (digit < 10) begin
        digits_low_first.push_back(ASCII_ZERO + CHAR_WIDTH'(digit));
      end else begin
        digits_low_first.push_back(ASCII_LOW_A + CHAR_WIDTH'(digit - 10));
      end
      magnitude = magnitude / base;
    end while (magnitude != 0);
    if (negative) begin
      entry.text_char = CHAR_MINUS;
      entry.is_last   = 1'b0;
      pending_chars.push_back(entry);
    end
    while (digits_low_first.size() > 0) begin
      entry.text_char = digits_low_first.pop_back();
      entry.is_last   = (digits_low_first.size() == 0);
      pending_chars.push_back(entry);
    end
  endfunction

  // Called at a rising edge; returns at the edge where the item is accepted.
  task automatic send_number(input logic [NUMBER_WIDTH-1:0] num,
                             input logic [RADIX_WIDTH-1:0] rdx,
                             input logic sgn);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.number    <= num;
    in_ch.radix     <= rdx;
    in_ch.as_signed <= sgn;
    do @(posedge clk); while (!in_ch.ready);
    predict_text(num, rdx, sgn);
    numbers_sent++;
  endtask

  task automatic test_directed();
    send_number(32'd0, 8'd10, 1'b0);
    send_number(32'd0, 8'd2, 1'b1);
    send_number(32'd1, 8'd2, 1'b0);
    send_number(32'hFFFF_FFFF, 8'd2, 1'b0);
    send_number(32'hFFFF_FFFF, 8'd16, 1'b0);
    send_number(32'hFFFF_FFFF, 8'd10, 1'b0);
    send_number(32'hFFFF_FFFF, 8'd8, 1'b0);
    send_number(32'hFFFF_FFFF, 8'd3, 1'b0);
    send_number(32'h8000_0000, 8'd10, 1'b0);
    send_number(32'hFFFF_FFFF, 8'd16, 1'b1);
    send_number(32'h8000_0000, 8'd10, 1'b1);
    send_number(32'h7FFF_FFFF, 8'd10, 1'b1);
    send_number(32'hFFFF_FFFB, 8'd2, 1'b1);
    send_number(32'd12345, 8'd16, 1'b1);
    // Radix values outside 2..16 fall back to decimal.
    send_number(32'd987654, 8'd0, 1'b0);
    send_number(32'd987654, 8'd1, 1'b0);
    send_number(32'd987654, 8'd17, 1'b0);
    send_number(32'd987654, 8'd255, 1'b0);
    send_number(32'd15, 8'd16, 1'b0);
    send_number(32'h00AB_CDEF, 8'd16, 1'b0);
    send_number(32'hDEAD_BEEF, 8'd7, 1'b0);
    send_number(32'h1234_5678, 8'd13, 1'b0);
    send_number(32'd9, 8'd9, 1'b0);
    send_number(32'd35, 8'd36, 1'b0);
  endtask

  task automatic send_random_number();
    logic [NUMBER_WIDTH-1:0] num;
    logic [RADIX_WIDTH-1:0]  rdx;
    case ($urandom_range(0, 3))
      0: num = $urandom;
      1: num = $urandom_range(0, 255);
      2: num = $urandom >> $urandom_range(0, 31);
      default: begin
        case ($urandom_range(0, 5))
          0: num = 32'd0;
          1: num = 32'd1;
          2: num = 32'h7FFF_FFFF;
          3: num = 32'h8000_0000;
          4: num = 32'hFFFF_FFFF;
          default: num = 32'd1 << $urandom_range(0, 31);
        endcase
      end
    endcase
    if ($urandom_range(0, 9) < 8) begin
      rdx = RADIX_WIDTH'($urandom_range(2, 16));
    end else begin
      rdx = RADIX_WIDTH'($urandom_range(0, 255));
    end
    send_number(num, rdx, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random();
    repeat (RANDOM_COUNT) send_random_number();
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (BURST_COUNT) send_random_number();
    no_gaps = 1'b0;
  endtask

  // The sink stops for a long stretch while numbers keep coming.
  task automatic test_receiver_hold();
    hold_request = 1'b1;
    no_gaps      = 1'b1;
    repeat (HOLD_COUNT) send_number($urandom, 8'd2, 1'b0);
    no_gaps = 1'b0;
  endtask

  initial begin : char_sink
    int stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
        holds_done++;
      end else if (no_gaps) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_WAIT);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                  out_ch.text_char, out_ch.is_last));
      end else begin
        text_char_t want;
        want = pending_chars.pop_front();
        if (out_ch.text_char !== want.text_char) begin
          report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
                                    out_ch.text_char, want.text_char));
        end
        if (out_ch.is_last !== want.is_last) begin
          report_mismatch($sformatf("is_last %0b, expected %0b on char 0x%02h",
                                    out_ch.is_last, want.is_last, want.text_char));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STUCK_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    mismatch_count  = 0;
    numbers_sent    = 0;
    chars_checked   = 0;
    holds_done      = 0;
    stuck_cycles    = 0;
    no_gaps         = 1'b0;
    hold_request    = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.number    = '0;
    in_ch.radix     = '0;
    in_ch.as_signed = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();
    test_back_to_back();
    test_receiver_hold();

    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d numbers in radix 2 to 16, signed decimal and fallback radix,",
             numbers_sent);
    $display("checked %0d characters, with random stalls, bursts and %0d long sink hold.",
             chars_checked, holds_done);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
